// ----- hdl/button_event_classifier_macros.svh -----
// Assertion macros shared by the checkers of the button event classifier.
`ifndef BUTTON_EVENT_CLASSIFIER_MACROS_SVH
`define BUTTON_EVENT_CLASSIFIER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define BEC_ASSERT_NOW(label, clk, rst_n, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define BEC_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
    else $error(msg);

`endif

// ----- hdl/bec_pkg.sv -----
package bec_pkg;

  // Event codes on the result channel
  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_CLICK  = 2'd1,
    EV_LONG   = 2'd2,
    EV_DOUBLE = 2'd3
  } event_e;

  // Press modes; the unused code behaves as plain click
  localparam logic [1:0] MODE_CLICK  = 2'd0;
  localparam logic [1:0] MODE_LONG   = 2'd1;
  localparam logic [1:0] MODE_REPEAT = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_PRESSED_LEVEL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_MODE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DBL_ENABLE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BEFORE_REPEAT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTV    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DBL_WINDOW     = 3'd7;

  // Reset values of the timing registers, in ms
  localparam logic [15:0] RST_DEBOUNCE      = 16'd50;
  localparam logic [15:0] RST_LONG_PRESS    = 16'd1000;
  localparam logic [15:0] RST_BEFORE_REPEAT = 16'd500;
  localparam logic [15:0] RST_REPEAT_INTV   = 16'd100;
  localparam logic [15:0] RST_DBL_WINDOW    = 16'd250;

  // Timestamp width and stream widths
  localparam int unsigned TIME_W = 32;
  localparam int unsigned IN_TDATA_W = 40;
  localparam int unsigned OUT_TDATA_W = 8;

  typedef struct packed {
    logic        pressed_level;
    logic [1:0]  press_mode;
    logic        dbl_click_enable;
    logic [15:0] min_hold_ms;
    logic [15:0] long_hold_ms;
    logic [15:0] rpt_delay_ms;
    logic [15:0] rpt_period_ms;
    logic [15:0] dbl_window_ms;
  } cfg_t;

endpackage

// ----- hdl/bec_cfg_regs.sv -----
module bec_cfg_regs
  import bec_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  // Write the addressed register; narrow registers keep the low bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pressed_level    <= 1'b0;
      cfg_r.press_mode       <= MODE_CLICK;
      cfg_r.dbl_click_enable <= 1'b0;
      cfg_r.min_hold_ms      <= RST_DEBOUNCE;
      cfg_r.long_hold_ms     <= RST_LONG_PRESS;
      cfg_r.rpt_delay_ms     <= RST_BEFORE_REPEAT;
      cfg_r.rpt_period_ms    <= RST_REPEAT_INTV;
      cfg_r.dbl_window_ms    <= RST_DBL_WINDOW;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PRESSED_LEVEL: cfg_r.pressed_level    <= cfg_wdata[0];
        REG_PRESS_MODE:    cfg_r.press_mode       <= cfg_wdata[1:0];
        REG_DBL_ENABLE:    cfg_r.dbl_click_enable <= cfg_wdata[0];
        REG_DEBOUNCE:      cfg_r.min_hold_ms      <= cfg_wdata;
        REG_LONG_PRESS:    cfg_r.long_hold_ms     <= cfg_wdata;
        REG_BEFORE_REPEAT: cfg_r.rpt_delay_ms     <= cfg_wdata;
        REG_REPEAT_INTV:   cfg_r.rpt_period_ms    <= cfg_wdata;
        REG_DBL_WINDOW:    cfg_r.dbl_window_ms    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hdl/bec_classify.sv -----
module bec_classify
  import bec_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              pin_level,
  input  logic [TIME_W-1:0] now_ms,
  input  cfg_t              cfg,
  output event_e            event_code
);

  logic [TIME_W-1:0] press_stamp_r, press_stamp_nxt;
  logic [TIME_W-1:0] release_stamp_r, release_stamp_nxt;
  logic              long_done_r, long_done_nxt;
  logic              repeat_active_r, repeat_active_nxt;
  logic [1:0]        click_count_r, click_count_nxt;

  logic [TIME_W-1:0] start_ms;
  logic [TIME_W-1:0] held_ms;
  logic [TIME_W-1:0] gap_ms;
  logic              is_held;
  logic              was_held;
  logic              ge_long, ge_before, ge_intv, ge_deb, win_expired;
  logic              repeat_now;
  logic [1:0]        click_inc;

  // Hold time and release gap, each one wrapping subtract
  assign is_held   = (pin_level == cfg.pressed_level);
  assign was_held  = (press_stamp_r != '0);
  assign start_ms  = was_held ? press_stamp_r : now_ms;
  assign held_ms   = now_ms - start_ms;
  assign gap_ms    = now_ms - release_stamp_r;

  assign ge_long     = held_ms >= {{(TIME_W-16){1'b0}}, cfg.long_hold_ms};
  assign ge_before   = held_ms >= {{(TIME_W-16){1'b0}}, cfg.rpt_delay_ms};
  assign ge_intv     = held_ms >= {{(TIME_W-16){1'b0}}, cfg.rpt_period_ms};
  assign ge_deb      = held_ms >= {{(TIME_W-16){1'b0}}, cfg.min_hold_ms};
  assign win_expired = gap_ms  >= {{(TIME_W-16){1'b0}}, cfg.dbl_window_ms};
  assign repeat_now  = repeat_active_r | ge_before;
  assign click_inc   = click_count_r + 2'd1;

  // Classify the poll and work out the next button state
  always_comb begin
    press_stamp_nxt   = press_stamp_r;
    release_stamp_nxt = release_stamp_r;
    long_done_nxt     = long_done_r;
    repeat_active_nxt = repeat_active_r;
    click_count_nxt   = click_count_r;
    event_code        = EV_NONE;
    if (is_held) begin
      press_stamp_nxt = start_ms;
      case (cfg.press_mode)
        MODE_LONG: begin
          if (long_done_r) begin
            press_stamp_nxt = '0;
          end else if (ge_long) begin
            long_done_nxt = 1'b1;
            event_code    = EV_LONG;
          end
        end
        MODE_REPEAT: begin
          repeat_active_nxt = repeat_now;
          if (repeat_now && ge_intv) begin
            press_stamp_nxt = now_ms;
            event_code      = EV_CLICK;
          end
        end
        default: ;
      endcase
    end else begin
      // Release ends a qualifying hold
      if (was_held && !repeat_active_r && ge_deb) begin
        if (cfg.dbl_click_enable) begin
          if (click_inc == 2'd2) begin
            click_count_nxt   = '0;
            release_stamp_nxt = '0;
            event_code        = EV_DOUBLE;
          end else begin
            click_count_nxt   = click_inc;
            release_stamp_nxt = now_ms;
          end
        end else begin
          event_code = EV_CLICK;
        end
      end
      // Lone release turns into a click once the window runs out
      if (!was_held && cfg.dbl_click_enable && release_stamp_r != '0 && win_expired) begin
        event_code        = EV_CLICK;
        click_count_nxt   = '0;
        release_stamp_nxt = '0;
      end
      long_done_nxt     = 1'b0;
      repeat_active_nxt = 1'b0;
      press_stamp_nxt   = '0;
    end
  end

  // Commit state once per poll
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_stamp_r   <= '0;
      release_stamp_r <= '0;
      long_done_r     <= 1'b0;
      repeat_active_r <= 1'b0;
      click_count_r   <= '0;
    end else if (step) begin
      press_stamp_r   <= press_stamp_nxt;
      release_stamp_r <= release_stamp_nxt;
      long_done_r     <= long_done_nxt;
      repeat_active_r <= repeat_active_nxt;
      click_count_r   <= click_count_nxt;
    end
  end

endmodule

// ----- hdl/button_event_classifier.sv -----
// Channel  | Dir | Handshake          | Payload
// in_      | in  | in_tvalid/tready   | in_tdata:  pin_level, now_ms
// out_     | out | out_tvalid/tready  | out_tdata: event_code
// cfg_     | in  | cfg_wr_en          | cfg_index, cfg_wdata
//
// One poll per clock cycle while the result side is not stalled; a poll leaves as a
// result after it is taken, through the input register and the result register.
// The classify logic (one 32-bit subtract per timestamp and a few compares)
// sits between those two registers.
// Reset is synchronous, active low, and clears state, configuration and valids.
// A stalled result holds in the output register; a new poll is still taken
// while the result register drains.
module button_event_classifier
  import bec_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [0] pin_level, [32:1] now_ms, rest zero
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [1:0] event_code, rest zero
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t              cfg;
  logic              poll_valid_r;
  logic              pin_level_r;
  logic [TIME_W-1:0] now_ms_r;
  logic              out_valid_r;
  event_e            event_code_r;
  event_e            event_code;
  logic              advance;

  bec_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Move a poll into the result register when that register is free
  assign advance   = poll_valid_r && (!out_valid_r || out_tready);
  assign in_tready = rst_n && (!poll_valid_r || advance);

  bec_classify u_classify (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .pin_level  (pin_level_r),
    .now_ms     (now_ms_r),
    .cfg        (cfg),
    .event_code (event_code)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_valid_r <= 1'b0;
    end else if (in_tready) begin
      poll_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      pin_level_r <= in_tdata[0];
      now_ms_r    <= in_tdata[TIME_W:1];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      event_code_r <= event_code;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-2){1'b0}}, event_code_r};

endmodule

// ----- hdl/bec_checker.sv -----
`include "button_event_classifier_macros.svh"

module bec_checker
  import bec_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // A stalled result keeps its transaction
  `BEC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  // Reset leaves no result pending
  `BEC_ASSERT_NEXT(a_rst_clear, clk, 1'b1, !rst_n, !out_tvalid, "result valid after reset")

  // An empty result register never blocks the input
  `BEC_ASSERT_NOW(a_ready_empty, clk, rst_n, !out_tvalid, in_tready, "input stalled with empty output")

  // A draining result frees room for the next transaction
  `BEC_ASSERT_NOW(a_ready_drain, clk, rst_n, out_tvalid && out_tready, in_tready, "input stalled while output drains")

endmodule

bind button_event_classifier bec_checker u_bec_checker (.*);

// ----- tb/tb_button_event_classifier.sv -----
module tb_button_event_classifier;
  timeunit 1ns;
  timeprecision 1ps;

  import bec_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500_000;
  localparam int unsigned RESULT_LATENCY = 4;
  // The press mode code that the block treats as plain click
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [0] pin_level, [32:1] now_ms, rest zero
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [1:0] event_code, rest zero
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // Shadow copy of the configuration and of the classifier state
  cfg_t        cur_cfg;
  logic [31:0] hold_start_ms;
  logic [31:0] first_release_ms;
  logic        long_fired;
  logic        repeating;
  logic [1:0]  release_count;

  event_e      pending_events[$];
  event_e      expected_ev;
  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned in_gap_pct = 0;
  int unsigned out_stall_pct = 0;
  int unsigned stall_left = 0;
  logic [31:0] now_t;

  button_event_classifier u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d events outstanding", cycle_count,
               pending_events.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Idle length: mostly short, now and then long
  function automatic int unsigned idle_len();
    return ($urandom_range(9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
  endfunction

  function automatic int unsigned pick_pct();
    case ($urandom_range(2))
      0:       return 0;
      1:       return 15;
      default: return 50;
    endcase
  endfunction

  function automatic logic [15:0] pick_ms();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return 16'($urandom_range(1, 400));
    endcase
  endfunction

  // Work out the event of one poll and advance the shadow state
  function automatic event_e classify_poll(input logic level, input logic [31:0] now);
    logic [31:0] held;
    logic        was_held;
    logic        dbl_on;
    event_e      ev;
    ev = EV_NONE;
    if (level == cur_cfg.pressed_level) begin
      if (hold_start_ms == '0) hold_start_ms = now;
      held = now - hold_start_ms;
      if (cur_cfg.press_mode == MODE_LONG) begin
        if (long_fired) hold_start_ms = '0;
        if (!long_fired && held >= 32'(cur_cfg.long_hold_ms)) begin
          long_fired = 1'b1;
          ev = EV_LONG;
        end
      end
      if (cur_cfg.press_mode == MODE_REPEAT) begin
        if (!repeating && held >= 32'(cur_cfg.rpt_delay_ms)) repeating = 1'b1;
        if (repeating && held >= 32'(cur_cfg.rpt_period_ms)) begin
          hold_start_ms = now;
          ev = EV_CLICK;
        end
      end
    end else begin
      was_held = (hold_start_ms != '0);
      dbl_on = cur_cfg.dbl_click_enable;
      held = now - hold_start_ms;
      // A qualifying release: pair it or report it at once
      if (was_held && !repeating && held >= 32'(cur_cfg.min_hold_ms)) begin
        if (dbl_on) begin
          first_release_ms = now;
          release_count = release_count + 2'd1;
          if (release_count == 2'd2) begin
            release_count = '0;
            first_release_ms = '0;
            ev = EV_DOUBLE;
          end
        end else begin
          ev = EV_CLICK;
        end
      end
      // Lone release turns into a click once the window has run out
      if (!was_held && dbl_on && first_release_ms != '0) begin
        if (now - first_release_ms >= 32'(cur_cfg.dbl_window_ms)) begin
          ev = EV_CLICK;
          release_count = '0;
          first_release_ms = '0;
        end
      end
      long_fired = 1'b0;
      repeating = 1'b0;
      hold_start_ms = '0;
    end
    return ev;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Send one poll, record its expected event, then maybe idle
  task automatic send_poll(input logic level, input logic [31:0] now);
    int unsigned gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_TDATA_W - TIME_W - 1){1'b0}}, now, level};
    do @(posedge clk); while (!in_tready);
    pending_events.push_back(classify_poll(level, now));
    items_sent++;
    if (in_gap_pct != 0 && $urandom_range(99) < in_gap_pct) begin
      gap = idle_len();
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Stop sending and wait for every outstanding transaction to come back
  task automatic hold_until_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_PRESSED_LEVEL: cur_cfg.pressed_level = val[0];
      REG_PRESS_MODE:    cur_cfg.press_mode = val[1:0];
      REG_DBL_ENABLE:    cur_cfg.dbl_click_enable = val[0];
      REG_DEBOUNCE:      cur_cfg.min_hold_ms = val;
      REG_LONG_PRESS:    cur_cfg.long_hold_ms = val;
      REG_BEFORE_REPEAT: cur_cfg.rpt_delay_ms = val;
      REG_REPEAT_INTV:   cur_cfg.rpt_period_ms = val;
      REG_DBL_WINDOW:    cur_cfg.dbl_window_ms = val;
      default: ;
    endcase
  endtask

  task automatic apply_config(input cfg_t c);
    write_reg(REG_PRESSED_LEVEL, CFG_DATA_W'(c.pressed_level));
    write_reg(REG_PRESS_MODE, CFG_DATA_W'(c.press_mode));
    write_reg(REG_DBL_ENABLE, CFG_DATA_W'(c.dbl_click_enable));
    write_reg(REG_DEBOUNCE, c.min_hold_ms);
    write_reg(REG_LONG_PRESS, c.long_hold_ms);
    write_reg(REG_BEFORE_REPEAT, c.rpt_delay_ms);
    write_reg(REG_REPEAT_INTV, c.rpt_period_ms);
    write_reg(REG_DBL_WINDOW, c.dbl_window_ms);
  endtask

  // Time step between polls, often landing close to a configured threshold
  function automatic int unsigned next_step();
    int unsigned thr;
    int unsigned step;
    int          near;
    case ($urandom_range(4))
      0:       thr = 32'(cur_cfg.min_hold_ms);
      1:       thr = 32'(cur_cfg.long_hold_ms);
      2:       thr = 32'(cur_cfg.rpt_delay_ms);
      3:       thr = 32'(cur_cfg.rpt_period_ms);
      default: thr = 32'(cur_cfg.dbl_window_ms);
    endcase
    case ($urandom_range(7))
      0:       step = 0;
      1, 2:    step = $urandom_range(1, 20);
      3, 4, 5: begin
        near = int'(thr) + int'($urandom_range(4)) - 2;
        step = (near < 0) ? 0 : near;
      end
      6:       step = $urandom_range(600);
      default: step = $urandom_range(70000);
    endcase
    return step;
  endfunction

  // One press-hold-release gesture, or a burst of noise
  task automatic run_gesture();
    logic        pl;
    int unsigned holds;
    pl = cur_cfg.pressed_level;
    case ($urandom_range(9))
      0: begin
        repeat ($urandom_range(1, 4)) begin
          now_t = $urandom();
          send_poll(1'($urandom_range(1)), now_t);
        end
      end
      default: begin
        if ($urandom_range(29) == 0) now_t = '0;
        else now_t += next_step();
        holds = $urandom_range(1, 6);
        repeat (holds) begin
          send_poll(pl, now_t);
          now_t += next_step();
        end
        send_poll(~pl, now_t);
        repeat ($urandom_range(3)) begin
          now_t += next_step();
          send_poll(~pl, now_t);
        end
      end
    endcase
    if ($urandom_range(39) == 0) hold_until_drained();
  endtask

  // Plain clicks with reset settings: zero stamp, wrap, short hold
  task automatic test_click_basics();
    send_poll(1'b0, 32'd0);
    send_poll(1'b0, 32'd10);
    send_poll(1'b1, 32'd100);
    send_poll(1'b0, 32'hFFFF_FFF0);
    send_poll(1'b1, 32'h0000_0040);
    send_poll(1'b0, 32'hFFFF_FFFF);
    send_poll(1'b1, 32'h0000_0005);
  endtask

  // Long press fires once, then the stamp clears and restarts
  task automatic test_long_press();
    hold_until_drained();
    write_reg(REG_PRESSED_LEVEL, 16'd1);
    write_reg(REG_PRESS_MODE, CFG_DATA_W'(MODE_LONG));
    write_reg(REG_LONG_PRESS, 16'd100);
    send_poll(1'b1, 32'd1000);
    send_poll(1'b1, 32'd1050);
    send_poll(1'b1, 32'd1100);
    send_poll(1'b1, 32'd1200);
    send_poll(1'b1, 32'd1300);
    send_poll(1'b0, 32'd1400);
  endtask

  // Auto repeat while held; the release click is suppressed
  task automatic test_auto_repeat();
    hold_until_drained();
    write_reg(REG_PRESS_MODE, CFG_DATA_W'(MODE_REPEAT));
    write_reg(REG_BEFORE_REPEAT, 16'd200);
    write_reg(REG_REPEAT_INTV, 16'd50);
    send_poll(1'b1, 32'd5000);
    send_poll(1'b1, 32'd5100);
    send_poll(1'b1, 32'd5200);
    send_poll(1'b1, 32'd5260);
    send_poll(1'b0, 32'd5300);
  endtask

  // Double click pairing and window expiry, in the unused press mode
  task automatic test_double_click();
    hold_until_drained();
    write_reg(REG_PRESS_MODE, CFG_DATA_W'(MODE_UNUSED));
    write_reg(REG_DBL_ENABLE, 16'd1);
    write_reg(REG_DEBOUNCE, 16'd0);
    write_reg(REG_DBL_WINDOW, 16'd250);
    send_poll(1'b1, 32'd100);
    send_poll(1'b0, 32'd200);
    send_poll(1'b1, 32'd300);
    send_poll(1'b0, 32'd400);
    send_poll(1'b1, 32'd500);
    send_poll(1'b0, 32'd600);
    send_poll(1'b0, 32'd700);
    send_poll(1'b0, 32'd900);
  endtask

  // Random gestures over several settings, the extremes first
  task automatic test_random_gestures(input int unsigned n_phases, input int unsigned per_phase);
    cfg_t        c;
    int unsigned stop_at;
    for (int unsigned p = 0; p < n_phases; p++) begin
      hold_until_drained();
      if (p == 0) begin
        c = '0;
      end else if (p == 1) begin
        c = '1;
      end else begin
        c.pressed_level = 1'($urandom_range(1));
        c.press_mode = 2'($urandom_range(3));
        c.dbl_click_enable = 1'($urandom_range(1));
        c.min_hold_ms = pick_ms();
        c.long_hold_ms = pick_ms();
        c.rpt_delay_ms = pick_ms();
        c.rpt_period_ms = pick_ms();
        c.dbl_window_ms = pick_ms();
      end
      apply_config(c);
      in_gap_pct = (p == 0) ? 0 : pick_pct();
      out_stall_pct = (p == 0) ? 0 : pick_pct();
      now_t = $urandom();
      stop_at = items_sent + per_phase;
      while (items_sent < stop_at) run_gesture();
    end
  endtask

  // Result side stalls
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (out_stall_pct != 0 && $urandom_range(99) < out_stall_pct) begin
      stall_left = idle_len() - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Check each result transaction against the oldest expected event
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event %0d", out_tdata[1:0]));
      end else begin
        expected_ev = pending_events.pop_front();
        if (out_tdata[1:0] !== expected_ev)
          report_mismatch($sformatf("event_code got %0d, expected %0d (%s)",
                                    out_tdata[1:0], expected_ev, expected_ev.name()));
      end
    end
  end

  initial begin
    cur_cfg = '{pressed_level: 1'b0, press_mode: MODE_CLICK, dbl_click_enable: 1'b0,
                min_hold_ms: RST_DEBOUNCE, long_hold_ms: RST_LONG_PRESS,
                rpt_delay_ms: RST_BEFORE_REPEAT, rpt_period_ms: RST_REPEAT_INTV,
                dbl_window_ms: RST_DBL_WINDOW};
    hold_start_ms = '0;
    first_release_ms = '0;
    long_fired = 1'b0;
    repeating = 1'b0;
    release_count = '0;
    now_t = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    in_gap_pct = 20;
    out_stall_pct = 20;
    test_click_basics();
    test_long_press();
    test_auto_repeat();
    test_double_click();
    test_random_gestures(12, 155);
    hold_until_drained();

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- button_event_classifier.f -----
+incdir+hdl
hdl/bec_pkg.sv
hdl/bec_cfg_regs.sv
hdl/bec_classify.sv
hdl/button_event_classifier.sv
hdl/bec_checker.sv
tb/tb_button_event_classifier.sv
